@@ rtl/core/bci_pkg.sv @@
// Shared types and constants for the battery charge integrator.
package bci_pkg;

	localparam int TABLE_DEPTH_DEF = 16;
	localparam int TIME_WIDTH_DEF  = 40;

	localparam int LEVEL_W = 17;
	localparam int KEY_W   = 7;
	localparam int RATE_W  = 22;
	localparam int USED_W  = 5;
	localparam int INDEX_W = 4;
	localparam int EVT_W   = 40;
	localparam int EL_W    = 41;
	localparam int SUM_W   = 63;
	localparam int DVD_W   = 38;
	localparam int QUO_W   = 17;
	localparam int DIV_W   = 22;
	localparam int CFG_IDX_W = 2;

	localparam logic [LEVEL_W-1:0] FULL_LEVEL      = 17'd65536;
	localparam logic [LEVEL_W-1:0] HALF_LEVEL      = 17'd32768;
	localparam logic [LEVEL_W-1:0] THRESHOLD_RESET = 17'd13107;
	localparam logic [EL_W-1:0]    ELAPSED_CAP     = 41'h100_0000_0000;
	localparam logic [DIV_W-1:0]   HOUR_MS         = 22'd3600000;
	localparam logic [SUM_W-1:0]   HALF_HOUR_MS    = 63'd1800000;
	// Any quotient above full scale clamps the same way, so larger sums saturate.
	localparam logic [SUM_W-1:0]   SUM_LIMIT       = 63'd235933200000;
	localparam logic [QUO_W-1:0]   QUO_SAT         = 17'd65537;

	localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_USED    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DISCHARGE_USED = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LOW_THRESHOLD  = 2'd2;

	typedef enum logic [1:0] {
		MODE_LOAD_CHARGE,
		MODE_LOAD_DISCHARGE,
		MODE_EVENT,
		MODE_PERIODIC
	} bci_mode_t;

	typedef enum logic {
		KIND_EVENT,
		KIND_PERIODIC
	} bci_kind_t;

	typedef struct packed {
		logic                     en;
		logic                     sel_charge;
		logic [INDEX_W-1:0]       index;
		logic [KEY_W-1:0]         key;
		logic signed [RATE_W-1:0] rate;
	} bci_load_t;

	typedef struct packed {
		logic                     valid;
		logic                     charging;
		logic [USED_W-1:0]        used;
		logic [KEY_W-1:0]         pct;
		logic                     have;
		logic [KEY_W-1:0]         best_key;
		logic [KEY_W-1:0]         best_dist;
		logic signed [RATE_W-1:0] best_rate;
	} bci_token_t;

endpackage

@@ rtl/core/bci_cell.sv @@
// One table slot of the search chain: holds a charge and a discharge entry.
module bci_cell #(
	parameter int IDX = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  bci_pkg::bci_load_t  load,
	input  bci_pkg::bci_token_t tok_in,
	output bci_pkg::bci_token_t tok_out
);

	logic [bci_pkg::KEY_W-1:0]         ch_key_q;
	logic signed [bci_pkg::RATE_W-1:0] ch_rate_q;
	logic [bci_pkg::KEY_W-1:0]         dc_key_q;
	logic signed [bci_pkg::RATE_W-1:0] dc_rate_q;
	bci_pkg::bci_token_t               tok_q;

	logic [bci_pkg::KEY_W-1:0]         key;
	logic signed [bci_pkg::RATE_W-1:0] rate;
	logic [bci_pkg::KEY_W-1:0]         gap;
	logic                              live;
	logic                              take;
	bci_pkg::bci_token_t               tok_nx;

	always_ff @(posedge clk) begin
		if (load.en && int'(load.index) == IDX) begin
			if (load.sel_charge) begin
				ch_key_q  <= load.key;
				ch_rate_q <= load.rate;
			end else begin
				dc_key_q  <= load.key;
				dc_rate_q <= load.rate;
			end
		end
	end

	always_comb begin
		key  = tok_in.charging ? ch_key_q : dc_key_q;
		rate = tok_in.charging ? ch_rate_q : dc_rate_q;
		gap  = (key > tok_in.pct) ? key - tok_in.pct : tok_in.pct - key;
		live = IDX < int'(tok_in.used);
		// Ties in distance go to the smaller key; equal keys keep the earlier slot.
		take = live && (!tok_in.have || gap < tok_in.best_dist ||
			(gap == tok_in.best_dist && key < tok_in.best_key));
		tok_nx = tok_in;
		if (take) begin
			tok_nx.have      = 1'b1;
			tok_nx.best_key  = key;
			tok_nx.best_dist = gap;
			tok_nx.best_rate = rate;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_nx;
		end
	end

	assign tok_out = tok_q;

endmodule

@@ rtl/core/bci_div.sv @@
// Division by one hour in milliseconds through a shift and a reciprocal multiply.
module bci_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [bci_pkg::DVD_W-1:0]   dividend,
	output logic                        done,
	output logic [bci_pkg::QUO_W-1:0]   quotient
);

	localparam int HOUR_SHIFT  = 7;
	localparam int SCALED_W    = bci_pkg::DVD_W - HOUR_SHIFT;
	localparam int RECIP_W     = 32;
	localparam int RECIP_SHIFT = 46;
	localparam int PROD_W      = SCALED_W + RECIP_W;
	localparam logic [RECIP_W-1:0] HOUR_RECIP = 32'd2501999793;

	logic [PROD_W-1:0] prod_q;
	logic              done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= start;
		end
	end

	// One hour is 128 * 28125. After the shift, the product with the rounded-up
	// reciprocal of 28125 gives the exact quotient for any 31-bit operand.
	always_ff @(posedge clk) begin
		if (start) begin
			prod_q <= PROD_W'(dividend[bci_pkg::DVD_W-1:HOUR_SHIFT]) * PROD_W'(HOUR_RECIP);
		end
	end

	assign done     = done_q;
	assign quotient = prod_q[RECIP_SHIFT +: bci_pkg::QUO_W];

endmodule

@@ rtl/core/battery_charge_integrator.sv @@
// Top level of the battery charge integrator: control sequencer and search chain.
//
// Usage: an item is taken on a rising edge with start high and busy low. The mode
// field picks a charge-table load, a discharge-table load, a battery event or a
// periodic check. Loads write one table slot and give no result. A periodic check,
// the first battery event and an event whose time equals the previous one give
// their result in the cycle after the item; busy stays low for these.
// An event that integrates runs the rounded percent through a chain of TABLE_DEPTH
// cells (one slot per cell, one cell per cycle); a shared 22x21 multiplier then takes
// the low and then the high half of the elapsed time, followed by the sum, its range
// check and the divide by one hour, which is skipped when the quotient is known to
// clamp. busy stays high through these steps, and the result is shown in the first
// cycle in which busy is low again.
// Each result is shown for one cycle with result_strobe; the receiver cannot stall.
// Configuration writes use cfg_valid/cfg_ready (always ready) and are meant for
// idle periods only.
// Reset clears the control state, sets both levels to half full, the threshold to
// its default and both used counts to zero. Table contents are undefined until
// loaded; there is no clearing pass.
module battery_charge_integrator #(
	parameter int TABLE_DEPTH = bci_pkg::TABLE_DEPTH_DEF,
	parameter int TIME_WIDTH  = bci_pkg::TIME_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [1:0]                          mode,
	input  logic [bci_pkg::INDEX_W-1:0]         entry_index,
	input  logic [bci_pkg::KEY_W-1:0]           entry_key,
	input  logic signed [bci_pkg::RATE_W-1:0]   entry_rate,
	input  logic [bci_pkg::EVT_W-1:0]           event_time_ms,
	input  logic                                charging,
	input  logic [bci_pkg::LEVEL_W-1:0]         reported_level,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [bci_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [bci_pkg::LEVEL_W-1:0]         cfg_data,
	output logic                                result_strobe,
	output logic                                result_kind,
	output logic [bci_pkg::LEVEL_W-1:0]         estimated_level,
	output logic [bci_pkg::LEVEL_W-1:0]         true_level,
	output logic [bci_pkg::LEVEL_W-1:0]         level_difference,
	output logic                                limit_warning,
	output logic                                true_below_threshold,
	output logic                                estimate_below_threshold
);

	localparam int EXT_W = (TIME_WIDTH > bci_pkg::EL_W) ? TIME_WIDTH : bci_pkg::EL_W;
	localparam int LO_W  = 21;
	localparam int PRD_W = bci_pkg::RATE_W + LO_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_SUM,
		ST_SAT,
		ST_DIV,
		ST_UPDATE
	} state_t;

	state_t                          state_q;
	logic [bci_pkg::LEVEL_W-1:0]     estimate_q;
	logic [bci_pkg::LEVEL_W-1:0]     real_q;
	logic [TIME_WIDTH-1:0]           prev_q;
	logic                            started_q;
	logic [bci_pkg::USED_W-1:0]      ch_used_q;
	logic [bci_pkg::USED_W-1:0]      dc_used_q;
	logic [bci_pkg::LEVEL_W-1:0]     threshold_q;
	logic [bci_pkg::EL_W-1:0]        el_q;
	logic [bci_pkg::RATE_W-1:0]      mag_q;
	logic                            neg_q;
	logic [PRD_W-1:0]                prod_lo_q;
	logic [PRD_W-2:0]                prod_hi_q;
	logic [bci_pkg::SUM_W-1:0]       sum_q;
	logic [bci_pkg::QUO_W-1:0]       quo_q;

	logic                            strobe_q;
	logic                            kind_q;
	logic [bci_pkg::LEVEL_W-1:0]     est_out_q;
	logic [bci_pkg::LEVEL_W-1:0]     real_out_q;
	logic [bci_pkg::LEVEL_W-1:0]     diff_out_q;
	logic                            warn_q;
	logic                            tb_q;
	logic                            eb_q;

	bci_pkg::bci_mode_t              mode_in;
	logic                            accept;
	logic [TIME_WIDTH-1:0]           now;
	logic [EXT_W-1:0]                elapsed_ext;
	logic [bci_pkg::EL_W-1:0]        elapsed_cap;
	logic [bci_pkg::LEVEL_W-1:0]     rep_sat;
	logic [23:0]                     pct_full;
	logic                            integrate;
	bci_pkg::bci_load_t              load;
	bci_pkg::bci_token_t             tok [0:TABLE_DEPTH];
	bci_pkg::bci_token_t             tail;
	logic signed [bci_pkg::RATE_W-1:0] tail_rate;
	logic [LO_W-1:0]                 mul_b;
	logic [PRD_W-1:0]                mul_p;
	logic                            div_start;
	logic                            div_done;
	logic [bci_pkg::QUO_W-1:0]       div_quo;
	logic [bci_pkg::LEVEL_W:0]       up_sum;
	logic [bci_pkg::LEVEL_W-1:0]     next_est;
	logic [bci_pkg::LEVEL_W-1:0]     evt_est;

	always_comb begin
		mode_in  = bci_pkg::bci_mode_t'(mode);
		accept   = start && !busy;
		now      = TIME_WIDTH'(event_time_ms);
		elapsed_ext = (now > prev_q) ? EXT_W'(now - prev_q) : '0;
		elapsed_cap = (elapsed_ext > EXT_W'(bci_pkg::ELAPSED_CAP)) ? bci_pkg::ELAPSED_CAP
			: elapsed_ext[bci_pkg::EL_W-1:0];
		rep_sat  = (reported_level > bci_pkg::FULL_LEVEL) ? bci_pkg::FULL_LEVEL
			: reported_level;
		pct_full = 24'(estimate_q) * 24'd100 + 24'd32768;
		integrate = accept && mode_in == bci_pkg::MODE_EVENT && started_q && now != prev_q;
		evt_est  = started_q ? estimate_q : rep_sat;
	end

	always_comb begin
		load.en         = accept && (mode_in == bci_pkg::MODE_LOAD_CHARGE ||
			mode_in == bci_pkg::MODE_LOAD_DISCHARGE);
		load.sel_charge = mode_in == bci_pkg::MODE_LOAD_CHARGE;
		load.index      = entry_index;
		load.key        = entry_key;
		load.rate       = entry_rate;
	end

	always_comb begin
		tok[0]           = '0;
		tok[0].valid     = integrate;
		tok[0].charging  = charging;
		tok[0].used      = charging ? ch_used_q : dc_used_q;
		tok[0].pct       = pct_full[22:16];
	end

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		bci_cell #(
			.IDX(i)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.load   (load),
			.tok_in (tok[i]),
			.tok_out(tok[i+1])
		);
	end

	assign tail      = tok[TABLE_DEPTH];
	assign tail_rate = tail.have ? tail.best_rate : '0;

	// One multiplier serves both halves of the elapsed time.
	always_comb begin
		mul_b = (state_q == ST_MUL_HI) ? LO_W'(el_q[bci_pkg::EL_W-1:LO_W])
			: el_q[LO_W-1:0];
		mul_p = PRD_W'(mag_q) * PRD_W'(mul_b);
	end

	assign div_start = state_q == ST_SAT && sum_q < bci_pkg::SUM_LIMIT;

	bci_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(sum_q[bci_pkg::DVD_W-1:0]),
		.done    (div_done),
		.quotient(div_quo)
	);

	always_comb begin
		up_sum = {1'b0, estimate_q} + {1'b0, quo_q};
		if (neg_q) begin
			next_est = (estimate_q < quo_q) ? '0 : estimate_q - quo_q;
		end else begin
			next_est = (up_sum > {1'b0, bci_pkg::FULL_LEVEL}) ? bci_pkg::FULL_LEVEL
				: up_sum[bci_pkg::LEVEL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_used_q   <= '0;
			dc_used_q   <= '0;
			threshold_q <= bci_pkg::THRESHOLD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				bci_pkg::CFG_CHARGE_USED:    ch_used_q   <= cfg_data[bci_pkg::USED_W-1:0];
				bci_pkg::CFG_DISCHARGE_USED: dc_used_q   <= cfg_data[bci_pkg::USED_W-1:0];
				bci_pkg::CFG_LOW_THRESHOLD:  threshold_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (integrate) begin
			el_q <= elapsed_cap;
		end
		if (state_q == ST_SEARCH && tail.valid) begin
			neg_q <= tail_rate[bci_pkg::RATE_W-1];
			mag_q <= tail_rate[bci_pkg::RATE_W-1] ? bci_pkg::RATE_W'(-tail_rate)
				: bci_pkg::RATE_W'(tail_rate);
		end
		if (state_q == ST_MUL_LO) begin
			prod_lo_q <= mul_p;
		end
		if (state_q == ST_MUL_HI) begin
			prod_hi_q <= mul_p[PRD_W-2:0];
		end
		if (state_q == ST_SUM) begin
			sum_q <= bci_pkg::SUM_W'(prod_lo_q) + (bci_pkg::SUM_W'(prod_hi_q) << LO_W)
				+ bci_pkg::HALF_HOUR_MS;
		end
		if (state_q == ST_SAT && !div_start) begin
			quo_q <= bci_pkg::QUO_SAT;
		end else if (state_q == ST_DIV && div_done) begin
			quo_q <= div_quo;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			estimate_q <= bci_pkg::HALF_LEVEL;
			real_q     <= bci_pkg::HALF_LEVEL;
			prev_q     <= '0;
			started_q  <= 1'b0;
			strobe_q   <= 1'b0;
			kind_q     <= 1'b0;
			est_out_q  <= '0;
			real_out_q <= '0;
			diff_out_q <= '0;
			warn_q     <= 1'b0;
			tb_q       <= 1'b0;
			eb_q       <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && mode_in == bci_pkg::MODE_PERIODIC) begin
						strobe_q   <= 1'b1;
						kind_q     <= bci_pkg::KIND_PERIODIC;
						est_out_q  <= estimate_q;
						real_out_q <= real_q;
						diff_out_q <= (real_q > estimate_q) ? real_q - estimate_q
							: estimate_q - real_q;
						warn_q     <= 1'b0;
						tb_q       <= real_q < threshold_q;
						eb_q       <= estimate_q < threshold_q;
					end else if (accept && mode_in == bci_pkg::MODE_EVENT) begin
						real_q    <= rep_sat;
						prev_q    <= now;
						started_q <= 1'b1;
						if (integrate) begin
							state_q <= ST_SEARCH;
						end else begin
							estimate_q <= evt_est;
							strobe_q   <= 1'b1;
							kind_q     <= bci_pkg::KIND_EVENT;
							est_out_q  <= evt_est;
							real_out_q <= rep_sat;
							diff_out_q <= (rep_sat > evt_est) ? rep_sat - evt_est
								: evt_est - rep_sat;
							warn_q     <= 1'b0;
							tb_q       <= 1'b0;
							eb_q       <= 1'b0;
						end
					end
				end
				ST_SEARCH: begin
					if (tail.valid) begin
						state_q <= ST_MUL_LO;
					end
				end
				ST_MUL_LO: state_q <= ST_MUL_HI;
				ST_MUL_HI: state_q <= ST_SUM;
				ST_SUM:    state_q <= ST_SAT;
				ST_SAT:    state_q <= div_start ? ST_DIV : ST_UPDATE;
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					estimate_q <= next_est;
					strobe_q   <= 1'b1;
					kind_q     <= bci_pkg::KIND_EVENT;
					est_out_q  <= next_est;
					real_out_q <= real_q;
					diff_out_q <= (real_q > next_est) ? real_q - next_est : next_est - real_q;
					warn_q     <= next_est == '0 || next_est == bci_pkg::FULL_LEVEL;
					tb_q       <= 1'b0;
					eb_q       <= 1'b0;
					state_q    <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy                     = state_q != ST_IDLE;
	assign cfg_ready                = 1'b1;
	assign result_strobe            = strobe_q;
	assign result_kind              = kind_q;
	assign estimated_level          = est_out_q;
	assign true_level               = real_out_q;
	assign level_difference         = diff_out_q;
	assign limit_warning            = warn_q;
	assign true_below_threshold     = tb_q;
	assign estimate_below_threshold = eb_q;

endmodule

@@ rtl/core/bci_checker.sv @@
// Port-level checks for the battery charge integrator, bound to the top level.
module bci_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                start,
	input logic                                busy,
	input logic [1:0]                          mode,
	input logic                                result_strobe,
	input logic                                result_kind,
	input logic [bci_pkg::LEVEL_W-1:0]         estimated_level,
	input logic [bci_pkg::LEVEL_W-1:0]         true_level,
	input logic [bci_pkg::LEVEL_W-1:0]         level_difference,
	input logic                                limit_warning,
	input logic                                true_below_threshold,
	input logic                                estimate_below_threshold
);

	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (mode == bci_pkg::MODE_LOAD_CHARGE ||
			mode == bci_pkg::MODE_LOAD_DISCHARGE) |=> !result_strobe)
		else $error("a table load produced a result");

	a_periodic_next: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && mode == bci_pkg::MODE_PERIODIC |=>
			result_strobe && result_kind == bci_pkg::KIND_PERIODIC)
		else $error("periodic item did not report in the next cycle");

	a_event_flags: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && result_kind == bci_pkg::KIND_EVENT |->
			!true_below_threshold && !estimate_below_threshold)
		else $error("event item carries threshold flags");

	a_periodic_warn: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && result_kind == bci_pkg::KIND_PERIODIC |-> !limit_warning)
		else $error("periodic item carries a limit warning");

	a_difference: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> estimated_level <= bci_pkg::FULL_LEVEL &&
			((true_level >= estimated_level &&
				level_difference == true_level - estimated_level) ||
			(true_level < estimated_level &&
				level_difference == estimated_level - true_level)))
		else $error("level difference does not match the reported levels");

endmodule

bind battery_charge_integrator bci_checker u_bci_checker (.*);
